// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/crm_pkg.sv =====
package crm_pkg;

    localparam int TIME_BITS      = 48;
    localparam int FIELD_BITS     = 48;
    localparam int COUNT_BITS     = 32;
    localparam int RATE_FRAC_BITS = 16;
    localparam int US_BITS        = 20;
    localparam int NUM_BITS       = COUNT_BITS + US_BITS;
    localparam int DIV_BITS       = NUM_BITS + RATE_FRAC_BITS;
    localparam int CNT_BITS       = $clog2(DIV_BITS);

    localparam logic [US_BITS-1:0]    US_PER_S  = 20'd1000000;
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

    typedef enum logic [2:0] {
        OUT_PENDING      = 3'd0,
        OUT_INITIAL      = 3'd1,
        OUT_STALLED      = 3'd2,
        OUT_INCREMENTAL  = 3'd3,
        OUT_INCONSISTENT = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic classify;
        logic mult;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/counter_rate_meter.sv =====
// Flow: a snapshot is accepted while idle, then classified, then its product is loaded
// into the divider; a rate is computed only for initial and incremental snapshots, by a
// radix-2 divider (one quotient bit per cycle over 68 bits), and the result is committed
// once the output is free. A new snapshot is taken only after the last one is committed.
// Reset (aresetn low, synchronous): stored snapshot, previous result and smoothing
// are cleared; the first snapshot after reset is classified as fresh.
module counter_rate_meter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [crm_pkg::COUNT_BITS-1:0]     s_event_count,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_reset_time,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_update_time,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_now_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [crm_pkg::FIELD_BITS-1:0]     m_interval_us,
    output logic [crm_pkg::FIELD_BITS-1:0]     m_rate_q16,
    output logic [2:0]                         m_outcome
);

    crm_pkg::cmd_t cmd;
    crm_pkg::sts_t sts;

    crm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    crm_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_event_count (s_event_count),
        .s_reset_time  (s_reset_time),
        .s_update_time (s_update_time),
        .s_now_time    (s_now_time),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_interval_us (m_interval_us),
        .m_rate_q16    (m_rate_q16),
        .m_outcome     (m_outcome)
    );

endmodule

// ===== design/crm_divider.sv =====
module crm_divider (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic                                step,
    input  logic [crm_pkg::DIV_BITS-1:0]        dividend,
    input  logic [crm_pkg::TIME_BITS-1:0]       divisor,
    output logic                                last,
    output logic [crm_pkg::FIELD_BITS-1:0]      quotient
);

    logic [crm_pkg::DIV_BITS-1:0]   dvd_reg, dvd_next;
    logic [crm_pkg::TIME_BITS-1:0]  rem_reg, rem_next;
    logic [crm_pkg::TIME_BITS-1:0]  den_reg, den_next;
    logic [crm_pkg::FIELD_BITS-1:0] quo_reg, quo_next;
    logic                           sat_reg, sat_next;
    logic [crm_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic [crm_pkg::TIME_BITS:0]    trial;
    logic [crm_pkg::TIME_BITS:0]    diff;
    logic                           ge;

    // restoring step: remainder stays below divisor, so trial fits TIME_BITS+1
    assign trial = {rem_reg, dvd_reg[crm_pkg::DIV_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    assign last     = cnt_reg == crm_pkg::CNT_BITS'(crm_pkg::DIV_BITS - 1);
    assign quotient = sat_reg ? crm_pkg::FIELD_MAX : quo_reg;

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        sat_next = sat_reg;
        cnt_next = cnt_reg;
        if (load) begin
            dvd_next = dividend;
            rem_next = '0;
            den_next = divisor;
            quo_next = '0;
            sat_next = 1'b0;
            cnt_next = '0;
        end else if (step) begin
            dvd_next = {dvd_reg[crm_pkg::DIV_BITS-2:0], 1'b0};
            rem_next = ge ? diff[crm_pkg::TIME_BITS-1:0] : trial[crm_pkg::TIME_BITS-1:0];
            quo_next = {quo_reg[crm_pkg::FIELD_BITS-2:0], ge};
            // a set bit leaving the field means the rate overflows
            sat_next = sat_reg | quo_reg[crm_pkg::FIELD_BITS-1];
            cnt_next = cnt_reg + crm_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

endmodule

// ===== design/crm_ctrl.sv =====
module crm_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  crm_pkg::sts_t sts,
    output crm_pkg::cmd_t cmd
);

    crm_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crm_pkg::ST_IDLE: begin
                if (s_valid) state_next = crm_pkg::ST_CLASSIFY;
            end
            crm_pkg::ST_CLASSIFY: begin
                state_next = crm_pkg::ST_MULT;
            end
            crm_pkg::ST_MULT: begin
                state_next = sts.needs_div ? crm_pkg::ST_DIVIDE : crm_pkg::ST_FINISH;
            end
            crm_pkg::ST_DIVIDE: begin
                if (sts.div_last) state_next = crm_pkg::ST_FINISH;
            end
            crm_pkg::ST_FINISH: begin
                if (sts.out_free) state_next = crm_pkg::ST_IDLE;
            end
            default: begin
                state_next = crm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            crm_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            crm_pkg::ST_CLASSIFY: begin
                cmd.classify = 1'b1;
            end
            crm_pkg::ST_MULT: begin
                cmd.mult = 1'b1;
            end
            crm_pkg::ST_DIVIDE: begin
                cmd.div_step = 1'b1;
            end
            crm_pkg::ST_FINISH: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/crm_datapath.sv =====
module crm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic [crm_pkg::COUNT_BITS-1:0]     s_event_count,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_reset_time,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_update_time,
    input  logic [crm_pkg::TIME_BITS-1:0]      s_now_time,
    input  crm_pkg::cmd_t                      cmd,
    output crm_pkg::sts_t                      sts,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [crm_pkg::FIELD_BITS-1:0]     m_interval_us,
    output logic [crm_pkg::FIELD_BITS-1:0]     m_rate_q16,
    output logic [2:0]                         m_outcome
);

    localparam int FB = crm_pkg::FIELD_BITS;
    localparam int TB = crm_pkg::TIME_BITS;

    // captured snapshot
    logic [crm_pkg::COUNT_BITS-1:0] cnt_in_reg;
    logic [TB-1:0]                  rst_in_reg, upd_in_reg, now_in_reg;

    // kept from the previous beat
    logic [crm_pkg::COUNT_BITS-1:0] prev_count_reg;
    logic [TB-1:0]                  prev_reset_reg, prev_update_reg;
    logic [FB-1:0]                  prev_ivl_reg, prev_rate_reg;
    logic                           smooth_reg;

    // classification results
    crm_pkg::outcome_t              outcome_reg, outcome_next;
    logic [FB-1:0]                  ivl_reg, ivl_next;
    logic [crm_pkg::COUNT_BITS-1:0] events_reg, events_next;

    logic                           m_valid_reg;
    logic [FB-1:0]                  out_ivl_reg, out_rate_reg;
    crm_pkg::outcome_t              out_outcome_reg;

    logic                           fresh, same;
    logic [TB-1:0]                  minuend, subtrahend;
    logic                           use_elapsed;
    logic [crm_pkg::NUM_BITS-1:0]   product;
    logic [FB-1:0]                  quotient, new_rate;
    logic [FB:0]                    ivl_sum, rate_sum;
    logic [FB-1:0]                  fin_ivl, fin_rate;
    logic                           div_last;

    assign fresh = (prev_update_reg == '0) || (rst_in_reg > prev_reset_reg);
    assign same  = (prev_update_reg != '0) && (rst_in_reg == prev_reset_reg);

    // one subtractor serves every case: pick operands, then clamp at zero
    always_comb begin
        outcome_next = crm_pkg::OUT_INCONSISTENT;
        minuend      = '0;
        subtrahend   = '0;
        use_elapsed  = 1'b0;
        events_next  = cnt_in_reg;
        if (fresh && upd_in_reg == '0) begin
            outcome_next = crm_pkg::OUT_PENDING;
            minuend      = now_in_reg;
            subtrahend   = rst_in_reg;
            use_elapsed  = 1'b1;
        end else if (fresh && upd_in_reg > rst_in_reg) begin
            outcome_next = crm_pkg::OUT_INITIAL;
            minuend      = upd_in_reg;
            subtrahend   = rst_in_reg;
            use_elapsed  = 1'b1;
        end else if (same && upd_in_reg == prev_update_reg) begin
            outcome_next = crm_pkg::OUT_STALLED;
            minuend      = now_in_reg;
            subtrahend   = prev_update_reg;
            use_elapsed  = 1'b1;
        end else if (same && upd_in_reg > prev_update_reg) begin
            outcome_next = crm_pkg::OUT_INCREMENTAL;
            minuend      = upd_in_reg;
            subtrahend   = prev_update_reg;
            use_elapsed  = 1'b1;
            events_next  = cnt_in_reg - prev_count_reg;
        end
        if (use_elapsed && minuend >= subtrahend) begin
            ivl_next = FB'(minuend - subtrahend);
        end else begin
            ivl_next = '0;
        end
    end

    assign sts.needs_div = (outcome_reg == crm_pkg::OUT_INITIAL) ||
                           (outcome_reg == crm_pkg::OUT_INCREMENTAL);
    assign sts.div_last  = div_last;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign product = crm_pkg::NUM_BITS'(events_reg) * crm_pkg::NUM_BITS'(crm_pkg::US_PER_S);

    crm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd.mult),
        .step     (cmd.div_step),
        .dividend ({product, {crm_pkg::RATE_FRAC_BITS{1'b0}}}),
        .divisor  (TB'(ivl_reg)),
        .last     (div_last),
        .quotient (quotient)
    );

    assign new_rate = sts.needs_div ? quotient : '0;
    assign ivl_sum  = {1'b0, prev_ivl_reg} + {1'b0, ivl_reg};
    assign rate_sum = {1'b0, prev_rate_reg} + {1'b0, new_rate};

    always_comb begin
        fin_ivl  = ivl_reg;
        fin_rate = new_rate;
        if (smooth_reg) begin
            if (prev_ivl_reg != '0 && ivl_reg != '0) begin
                fin_ivl  = ivl_sum[FB:1];
                fin_rate = rate_sum[FB:1];
            end else if (prev_ivl_reg != '0) begin
                fin_ivl  = prev_ivl_reg;
                fin_rate = prev_rate_reg;
            end else if (ivl_reg == '0) begin
                fin_rate = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg  <= '0;
            prev_reset_reg  <= '0;
            prev_update_reg <= '0;
            prev_ivl_reg    <= '0;
            prev_rate_reg   <= '0;
            smooth_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) smooth_reg <= cfg_wdata;
            if (cmd.commit) begin
                prev_count_reg  <= cnt_in_reg;
                prev_reset_reg  <= rst_in_reg;
                prev_update_reg <= upd_in_reg;
                prev_ivl_reg    <= fin_ivl;
                prev_rate_reg   <= fin_rate;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cnt_in_reg <= s_event_count;
            rst_in_reg <= s_reset_time;
            upd_in_reg <= s_update_time;
            now_in_reg <= s_now_time;
        end
        if (cmd.classify) begin
            outcome_reg <= outcome_next;
            ivl_reg     <= ivl_next;
            events_reg  <= events_next;
        end
        if (cmd.commit) begin
            out_ivl_reg     <= fin_ivl;
            out_rate_reg    <= fin_rate;
            out_outcome_reg <= outcome_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_interval_us = out_ivl_reg;
    assign m_rate_q16    = out_rate_reg;
    assign m_outcome     = out_outcome_reg;

endmodule

// ===== design/crm_checker.sv =====
`include "assert_macros.svh"

module crm_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [crm_pkg::FIELD_BITS-1:0]     m_interval_us,
    input  logic [crm_pkg::FIELD_BITS-1:0]     m_rate_q16,
    input  logic [2:0]                         m_outcome
);

    // stalled result beat holds
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_interval_us) && $stable(m_rate_q16) && $stable(m_outcome), "result beat changed while stalled")

    // a zero interval never carries a rate
    `ASSERT_CLK(a_zero_ivl_rate, m_valid && m_interval_us == '0 |-> m_rate_q16 == '0, "nonzero rate with zero interval")

    // one snapshot in flight at a time
    `ASSERT_CLK(a_one_in_flight, s_valid && s_ready |=> !s_ready, "second snapshot taken back to back")

    `ASSERT_CLK_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind counter_rate_meter crm_checker u_crm_checker (.*);
